@@ hw/rtl/mmu_pkg.sv @@
// Package for the mask modulate block: payload types, register indexes and
// the fixed widths of the image geometry. No dependencies.
package mmu_pkg;

  localparam int IMG_W   = 13;    // width and height register width
  localparam int POS_W   = 12;    // pixel column and row counter width
  localparam int SCL_W   = 5;     // scale register width
  localparam int CNT_W   = 3;     // channel count register width
  localparam int SAMP_W  = 16;    // colour, mask and result sample width
  localparam int CFG_IDX_W = 3;
  localparam int MAX_DIM = 4096;

  localparam logic [CNT_W-1:0] THREE_CHANNELS = CNT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_SCALE         = 3'd2,
    CFG_WIDE_SAMPLES  = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SAMP_W-1:0]   mask_address;
    logic [SAMP_W-1:0]   mask_value;
    logic [SAMP_W-1:0]   colour_0;
    logic [SAMP_W-1:0]   colour_1;
    logic [SAMP_W-1:0]   colour_2;
    logic [SAMP_W-1:0]   colour_3;
  } mmu_in_t;

  typedef struct packed {
    logic [SAMP_W-1:0]   result_0;
    logic [SAMP_W-1:0]   result_1;
    logic [SAMP_W-1:0]   result_2;
    logic [SAMP_W-1:0]   result_3;
    logic                frame_end;
  } mmu_out_t;

endpackage

@@ hw/rtl/mmu_if.sv @@
// Valid/ready stream interfaces for the input and result channels of the
// mask modulate block. Depends on mmu_pkg for the payload types.
interface mmu_in_if import mmu_pkg::*; ();
  logic    valid;
  logic    ready;
  mmu_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmu_out_if import mmu_pkg::*; ();
  logic     valid;
  logic     ready;
  mmu_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mmu_div.sv @@
// Mask row pitch unit: image width divided by scale, one quotient bit per
// cycle, then reduced modulo the mask depth. Depends on mmu_pkg.
module mmu_div import mmu_pkg::*; #(
  parameter int MASK_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [IMG_W-1:0]                dividend,
  input  logic [SCL_W-1:0]                divisor,
  output logic                            busy,
  output logic [$clog2(MASK_DEPTH)-1:0]   pitch
);

  localparam int AW   = $clog2(MASK_DEPTH);
  localparam int STEP_W = $clog2(IMG_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REDUCE
  } div_state_t;

  div_state_t         state_r;
  logic [STEP_W-1:0]  step_r;
  logic [IMG_W-1:0]   dvd_r;
  logic [IMG_W-1:0]   quo_r;
  logic [SCL_W-1:0]   rem_r;
  logic [AW-1:0]      pitch_r;

  logic [SCL_W:0]     trial;
  logic               fits;
  logic               over_depth;

  assign trial      = {rem_r, dvd_r[IMG_W-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign over_depth = 32'(quo_r) >= MASK_DEPTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pitch_r <= AW'(1);
      step_r  <= '0;
    end else if (start) begin
      state_r <= ST_DIVIDE;
      step_r  <= STEP_W'(IMG_W);
      dvd_r   <= dividend;
      quo_r   <= '0;
      rem_r   <= '0;
    end else begin
      case (state_r)
        ST_DIVIDE: begin
          rem_r  <= fits ? SCL_W'(trial - {1'b0, divisor}) : SCL_W'(trial);
          quo_r  <= {quo_r[IMG_W-2:0], fits};
          dvd_r  <= {dvd_r[IMG_W-2:0], 1'b0};
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          // The pitch can exceed a small mask store, so wrap it one depth
          // at a time before it is used by the row address adder.
          if (over_depth) begin
            quo_r <= quo_r - IMG_W'(MASK_DEPTH);
          end else begin
            pitch_r <= AW'(quo_r);
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy  = (state_r != ST_IDLE);
  assign pitch = pitch_r;

endmodule

@@ hw/rtl/mmu_norm.sv @@
// One colour channel: sample times mask, then truncating division by 255
// or 65535 through a shift-and-add correction. Depends on mmu_pkg.
module mmu_norm import mmu_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               wide,
  input  logic [SAMP_W-1:0]  colour,
  input  logic [SAMP_W-1:0]  mask,
  output logic [SAMP_W-1:0]  result
);

  logic [2*SAMP_W-1:0] prod_wide;
  logic [SAMP_W-1:0]   prod_narrow;
  logic [2*SAMP_W-1:0] prod_r;
  logic [2*SAMP_W:0]   sum_wide;
  logic [SAMP_W:0]     sum_narrow;
  logic [SAMP_W-1:0]   result_r;

  assign prod_wide   = (2*SAMP_W)'(colour) * (2*SAMP_W)'(mask);
  assign prod_narrow = SAMP_W'(colour[7:0]) * SAMP_W'(mask[7:0]);

  // floor(p / (2^k - 1)) equals (p + (p >> k) + 1) >> k for every product
  // of two k-bit samples, so no divider is needed.
  assign sum_wide   = (2*SAMP_W+1)'(prod_r) + (2*SAMP_W+1)'(prod_r[2*SAMP_W-1:SAMP_W])
                    + (2*SAMP_W+1)'(1);
  assign sum_narrow = (SAMP_W+1)'(prod_r[SAMP_W-1:0]) + (SAMP_W+1)'(prod_r[SAMP_W-1:8])
                    + (SAMP_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= wide ? prod_wide : {{SAMP_W{1'b0}}, prod_narrow};
      result_r <= wide ? sum_wide[2*SAMP_W-1:SAMP_W] : {8'b0, sum_narrow[SAMP_W-1:8]};
    end
  end

  assign result = result_r;

endmodule

@@ hw/rtl/mask_modulate_upsampled.sv @@
// Mask modulate with nearest-neighbour upsampled mask: top level.
// Depends on mmu_pkg, mmu_if, mmu_div and mmu_norm.
//
// Usage: write the geometry and sample mode on the cfg_ port while idle,
// send load beats (opcode 0) to fill the mask store, then send colour
// pixels (opcode 1) in raster order on in_chan. Each pixel gives one
// result beat on out_chan; loads give none. frame_end marks the last pixel
// of a frame, after which the position counters restart at zero.
// An accepted pixel passes the registered mask read, multiply and normalise
// stages before it appears on out_chan. Throughput: one beat per cycle,
// loads and pixels alike, while out_chan takes results and no pitch is computed.
// A write to the width or scale register recomputes the mask row pitch
// with a bit-serial divider: in_chan.ready stays low while it divides and
// while it wraps the pitch one depth at a time when it reaches MASK_DEPTH.
// Reset (rst_n low, synchronous) empties the pipeline and returns the
// counters and registers to their defaults; the mask store keeps its
// contents and is undefined until loaded. When out_chan stalls, all three
// stages hold and in_chan.ready falls.
module mask_modulate_upsampled import mmu_pkg::*; #(
  parameter int MASK_DEPTH = 65536,
  parameter int MAX_SCALE  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mmu_in_if.sink                in_chan,
  mmu_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [IMG_W-1:0]      cfg_wdata
);

  localparam int AW   = $clog2(MASK_DEPTH);
  localparam int PH_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  // Configuration registers.
  logic [IMG_W-1:0] width_r;
  logic [IMG_W-1:0] height_r;
  logic [SCL_W-1:0] scale_r;
  logic             wide_r;
  logic [CNT_W-1:0] chan_cnt_r;
  logic             div_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= IMG_W'(1);
      height_r    <= IMG_W'(1);
      scale_r     <= SCL_W'(1);
      wide_r      <= 1'b0;
      chan_cnt_r  <= CNT_W'(4);
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IMAGE_WIDTH: begin
            width_r     <= cfg_wdata;
            div_start_r <= 1'b1;
          end
          CFG_IMAGE_HEIGHT:  height_r   <= cfg_wdata;
          CFG_SCALE: begin
            scale_r     <= cfg_wdata[SCL_W-1:0];
            div_start_r <= 1'b1;
          end
          CFG_WIDE_SAMPLES:  wide_r     <= cfg_wdata[0];
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Effective geometry after clamping.
  logic [IMG_W-1:0] w_eff;
  logic [IMG_W-1:0] h_eff;
  logic [SCL_W-1:0] s_eff;
  logic [POS_W-1:0] last_col;
  logic [POS_W-1:0] last_row;

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) w_eff = IMG_W'(1);
    else if (32'(width_r) > MAX_DIM) w_eff = IMG_W'(MAX_DIM);
    h_eff = height_r;
    if (height_r == '0) h_eff = IMG_W'(1);
    else if (32'(height_r) > MAX_DIM) h_eff = IMG_W'(MAX_DIM);
    s_eff = scale_r;
    if (scale_r == '0) s_eff = SCL_W'(1);
    else if (32'(scale_r) > MAX_SCALE) s_eff = SCL_W'(MAX_SCALE);
  end

  assign last_col = POS_W'(w_eff - IMG_W'(1));
  assign last_row = POS_W'(h_eff - IMG_W'(1));

  logic          div_busy;
  logic [AW-1:0] pitch;

  mmu_div #(
    .MASK_DEPTH (MASK_DEPTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (w_eff),
    .divisor  (s_eff),
    .busy     (div_busy),
    .pitch    (pitch)
  );

  // Handshake and pipeline enable.
  logic out_valid_r;
  logic en;
  logic accept;
  logic acc_pix;
  logic acc_load;

  assign en       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en && !div_start_r && !div_busy;
  assign accept   = in_chan.valid && in_chan.ready;
  assign acc_pix  = accept && (in_chan.data.opcode == OP_PIXEL);
  assign acc_load = accept && (in_chan.data.opcode == OP_LOAD);

  // Raster position and mask address.
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  cph_r, cph_nxt;
  logic [PH_W-1:0]  rph_r, rph_nxt;
  logic [AW-1:0]    row_start_r, row_start_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;

  logic             row_end;
  logic             frame_end;
  logic [PH_W:0]    cph_inc;
  logic [PH_W:0]    rph_inc;
  logic             cph_wrap;
  logic             rph_wrap;
  logic [AW:0]      rs_sum;
  logic [AW-1:0]    rs_plus;
  logic [AW-1:0]    addr_inc;

  assign row_end   = col_r >= last_col;
  assign frame_end = row_end && (row_r >= last_row);
  assign cph_inc   = {1'b0, cph_r} + (PH_W+1)'(1);
  assign rph_inc   = {1'b0, rph_r} + (PH_W+1)'(1);
  assign cph_wrap  = 32'(cph_inc) >= 32'(s_eff);
  assign rph_wrap  = 32'(rph_inc) >= 32'(s_eff);
  assign rs_sum    = {1'b0, row_start_r} + {1'b0, pitch};
  assign rs_plus   = (32'(rs_sum) >= MASK_DEPTH) ? AW'(rs_sum - (AW+1)'(MASK_DEPTH))
                                                 : AW'(rs_sum);
  assign addr_inc  = (32'(addr_r) == MASK_DEPTH - 1) ? '0 : addr_r + AW'(1);

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    cph_nxt       = cph_r;
    rph_nxt       = rph_r;
    row_start_nxt = row_start_r;
    addr_nxt      = addr_r;
    if (acc_pix) begin
      if (frame_end) begin
        col_nxt       = '0;
        row_nxt       = '0;
        cph_nxt       = '0;
        rph_nxt       = '0;
        row_start_nxt = '0;
        addr_nxt      = '0;
      end else if (row_end) begin
        col_nxt = '0;
        cph_nxt = '0;
        row_nxt = row_r + POS_W'(1);
        if (rph_wrap) begin
          rph_nxt       = '0;
          row_start_nxt = rs_plus;
          addr_nxt      = rs_plus;
        end else begin
          rph_nxt  = PH_W'(rph_inc);
          addr_nxt = row_start_r;
        end
      end else begin
        col_nxt = col_r + POS_W'(1);
        if (cph_wrap) begin
          cph_nxt  = '0;
          addr_nxt = addr_inc;
        end else begin
          cph_nxt = PH_W'(cph_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cph_r       <= '0;
      rph_r       <= '0;
      row_start_r <= '0;
      addr_r      <= '0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cph_r       <= cph_nxt;
      rph_r       <= rph_nxt;
      row_start_r <= row_start_nxt;
      addr_r      <= addr_nxt;
    end
  end

  // Mask store: loads write at acceptance, pixels read at acceptance.
  logic [SAMP_W-1:0] mask_mem [MASK_DEPTH];
  logic [SAMP_W-1:0] mask_rd_r;
  logic [AW-1:0]     ld_idx;
  logic              ld_in_range;

  assign ld_idx      = AW'(in_chan.data.mask_address);
  assign ld_in_range = 32'(in_chan.data.mask_address) < MASK_DEPTH;

  always_ff @(posedge clk) begin
    if (acc_load && ld_in_range) begin
      mask_mem[ld_idx] <= in_chan.data.mask_value;
    end
    if (acc_pix) begin
      mask_rd_r <= mask_mem[addr_r];
    end
  end

  // Pipeline stage one: colour samples held beside the mask read.
  logic              s1_valid_r, s2_valid_r;
  logic              s1_fe_r, s2_fe_r, out_fe_r;
  logic [SAMP_W-1:0] col0_r, col1_r, col2_r, col3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= acc_pix;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fe_r  <= frame_end;
      s2_fe_r  <= s1_fe_r;
      out_fe_r <= s2_fe_r;
      col0_r   <= in_chan.data.colour_0;
      col1_r   <= in_chan.data.colour_1;
      col2_r   <= in_chan.data.colour_2;
      // With three channels the fourth product is forced to zero here.
      col3_r   <= (chan_cnt_r == THREE_CHANNELS) ? '0 : in_chan.data.colour_3;
    end
  end

  logic [SAMP_W-1:0] res0, res1, res2, res3;

  mmu_norm u_norm0 (.clk(clk), .en(en), .wide(wide_r), .colour(col0_r),
                    .mask(mask_rd_r), .result(res0));
  mmu_norm u_norm1 (.clk(clk), .en(en), .wide(wide_r), .colour(col1_r),
                    .mask(mask_rd_r), .result(res1));
  mmu_norm u_norm2 (.clk(clk), .en(en), .wide(wide_r), .colour(col2_r),
                    .mask(mask_rd_r), .result(res2));
  mmu_norm u_norm3 (.clk(clk), .en(en), .wide(wide_r), .colour(col3_r),
                    .mask(mask_rd_r), .result(res3));

  assign out_chan.valid          = out_valid_r;
  assign out_chan.data.result_0  = res0;
  assign out_chan.data.result_1  = res1;
  assign out_chan.data.result_2  = res2;
  assign out_chan.data.result_3  = res3;
  assign out_chan.data.frame_end = out_fe_r;

  // Checks on the block's own control.
  a_no_accept_while_dividing : assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy || div_start_r) |-> !in_chan.ready)
    else $error("input beat accepted while the row pitch is being computed");

  a_frame_end_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    (acc_pix && frame_end) |=> (col_r == '0 && row_r == '0 && addr_r == '0))
    else $error("position counters did not restart after the last pixel");

  a_phase_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cph_r) < MAX_SCALE) && (32'(rph_r) < MAX_SCALE))
    else $error("scale phase counter out of range");

  a_stall_holds_stage : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !en) |=> s1_valid_r)
    else $error("pixel lost from the mask read stage during a stall");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for mask_modulate_upsampled: directed beats, then random
// geometry phases with idle and stall patterns. Depends on mmu_pkg and mmu_if.
`timescale 1ns / 1ps

module tb;
  import mmu_pkg::*;

  localparam int MASK_ENTRIES  = 65536;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BEATS  = 1150;
  localparam int PRELOAD_MAX   = 64;

  typedef enum logic {
    STEP_BEAT,
    STEP_REG
  } step_kind_t;

  // For register steps the value travels in beat.mask_value.
  typedef struct {
    step_kind_t kind;
    cfg_idx_t   reg_idx;
    mmu_in_t    beat;
    bit         typed;
    mmu_out_t   want;
  } plan_row_t;

  localparam mmu_out_t NO_PIXEL = '0;
  localparam int PLAN_LEN = 29;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IMG_W-1:0]     cfg_wdata;

  mmu_in_if  in_if ();
  mmu_out_if out_if ();

  mask_modulate_upsampled dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  plan_row_t directed_plan [PLAN_LEN] = '{
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'h00FF, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1}},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'hFF00, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'h0080, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h00FF, 16'h0001, 16'h0080, 16'hABFF}, 1'b1,
      '{16'h0080, 16'h0000, 16'h0040, 16'h0080, 1'b1}},
    '{STEP_REG, CFG_WIDE_SAMPLES,
      '{OP_LOAD, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001}, 1'b1,
      '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b1}},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h5555}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_CHANNEL_COUNT,
      '{OP_LOAD, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1}},
    '{STEP_REG, CFG_CHANNEL_COUNT,
      '{OP_LOAD, 16'h0000, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h1234, 16'h8001, 16'h7FFF, 16'hFFFF}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_WIDE_SAMPLES,
      '{OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_IMAGE_HEIGHT,
      '{OP_LOAD, 16'h0000, 16'h1FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0001, 16'h00C3, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0002, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h5A5A, 16'hC3C3, 16'h00FF, 16'hFF00}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h0080, 16'h0001, 16'hFFFF, 16'h7F7F}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_IMAGE_HEIGHT,
      '{OP_LOAD, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_LOAD, 16'h0003, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h00FE, 16'h00FF, 16'h0001, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_REG, CFG_SCALE,
      '{OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_PIXEL},
    '{STEP_BEAT, CFG_IMAGE_WIDTH,
      '{OP_PIXEL, 16'h0000, 16'h0000, 16'h8000, 16'h00FF, 16'h0F0F, 16'hF0F0}, 1'b0, NO_PIXEL}
  };

  // Predictor state: shadow registers, mask store and raster position.
  logic [IMG_W-1:0]  cfg_width, cfg_height;
  logic [SCL_W-1:0]  cfg_scale;
  logic              cfg_wide;
  logic [CNT_W-1:0]  cfg_chans;
  logic [SAMP_W-1:0] mask_mem [MASK_ENTRIES];
  bit                mask_written [MASK_ENTRIES];
  logic [POS_W-1:0]  pix_col, pix_row, mask_col;
  logic [SCL_W-1:0]  col_phase, row_phase;
  logic [SAMP_W-1:0] mask_base;

  mmu_out_t pending_pixels [$];
  int       mismatches;
  int       beats_sent;
  int       send_idle_pct, recv_stall_pct;
  int       hold_requests, hold_taken, hold_left;
  int       cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned clamp_dim(input logic [IMG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return raw;
  endfunction

  function automatic int unsigned scale_of(input logic [SCL_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > 16) return 16;
    return raw;
  endfunction

  function automatic logic [SAMP_W-1:0] read_address();
    return mask_base + SAMP_W'(mask_col);
  endfunction

  function automatic logic [SAMP_W-1:0] scale_sample(input logic [SAMP_W-1:0] colour,
                                                     input logic [SAMP_W-1:0] m);
    logic [31:0] prod;
    if (cfg_wide) begin
      prod = {16'h0, colour} * {16'h0, m};
      return SAMP_W'(prod / 32'd65535);
    end
    prod = {24'h0, colour[7:0]} * {24'h0, m[7:0]};
    return SAMP_W'(prod / 32'd255);
  endfunction

  task automatic modulate_beat(input mmu_in_t beat, output bit produced,
                               output mmu_out_t res);
    int unsigned w, h, s;
    logic [SAMP_W-1:0] m;
    bit row_end, last;
    res = '0;
    produced = 1'b0;
    if (beat.opcode == OP_LOAD) begin
      mask_mem[beat.mask_address] = beat.mask_value;
      mask_written[beat.mask_address] = 1'b1;
    end else begin
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      s = scale_of(cfg_scale);
      m = mask_mem[read_address()];
      res.result_0 = scale_sample(beat.colour_0, m);
      res.result_1 = scale_sample(beat.colour_1, m);
      res.result_2 = scale_sample(beat.colour_2, m);
      res.result_3 = scale_sample(beat.colour_3, m);
      if (cfg_chans == THREE_CHANNELS) res.result_3 = '0;
      // A shrunken geometry ends the row or frame at any position past its end.
      row_end = pix_col >= w - 1;
      last = row_end && (pix_row >= h - 1);
      res.frame_end = last;
      produced = 1'b1;
      if (last) begin
        pix_col = '0; pix_row = '0; col_phase = '0; row_phase = '0;
        mask_col = '0; mask_base = '0;
      end else if (row_end) begin
        pix_col = '0; col_phase = '0; mask_col = '0;
        pix_row = pix_row + 1'b1;
        row_phase = row_phase + 1'b1;
        if (row_phase >= s) begin
          row_phase = '0;
          mask_base = mask_base + SAMP_W'(w / s);
        end
      end else begin
        pix_col = pix_col + 1'b1;
        col_phase = col_phase + 1'b1;
        if (col_phase >= s) begin
          col_phase = '0;
          mask_col = mask_col + 1'b1;
        end
      end
    end
  endtask

  task automatic report_field(input string name, input logic [SAMP_W-1:0] want,
                              input logic [SAMP_W-1:0] got);
    $display("%0t: %s expected %h, got %h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic compare_pixel(input mmu_out_t got);
    mmu_out_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: result beat %h arrived with none pending", $time, got);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.result_0 !== want.result_0) report_field("result_0", want.result_0, got.result_0);
      if (got.result_1 !== want.result_1) report_field("result_1", want.result_1, got.result_1);
      if (got.result_2 !== want.result_2) report_field("result_2", want.result_2, got.result_2);
      if (got.result_3 !== want.result_3) report_field("result_3", want.result_3, got.result_3);
      if (got.frame_end !== want.frame_end)
        report_field("frame_end", want.frame_end, got.frame_end);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      compare_pixel(out_if.data);
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results pending", $time, pending_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [SAMP_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'hFF00;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [IMG_W-1:0] with_junk(input int value, input int bits);
    logic [IMG_W-1:0] v;
    v = IMG_W'(value);
    if ($urandom_range(3) == 0) v = v | (IMG_W'($urandom) << bits);
    return v;
  endfunction

  // Leaves valid high after acceptance so that back-to-back beats need one assignment.
  task automatic send_beat(input mmu_in_t beat, input bit typed, input mmu_out_t want);
    bit produced;
    mmu_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= beat;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    modulate_beat(beat, produced, res);
    if (produced) pending_pixels.push_back(typed ? want : res);
    beats_sent++;
  endtask

  task automatic send_load(input logic [SAMP_W-1:0] addr, input logic [SAMP_W-1:0] value);
    mmu_in_t beat;
    beat = '{OP_LOAD, addr, value, pick_sample(), pick_sample(), pick_sample(),
             pick_sample()};
    send_beat(beat, 1'b0, NO_PIXEL);
  endtask

  // A pixel must never read a mask entry that has not been loaded.
  task automatic send_pixel(input mmu_in_t beat, input bit typed, input mmu_out_t want);
    if (!mask_written[read_address()]) send_load(read_address(), pick_sample());
    send_beat(beat, typed, want);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [IMG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:   cfg_width = value;
      CFG_IMAGE_HEIGHT:  cfg_height = value;
      CFG_SCALE:         cfg_scale = value[SCL_W-1:0];
      CFG_WIDE_SAMPLES:  cfg_wide = value[0];
      CFG_CHANNEL_COUNT: cfg_chans = value[CNT_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    plan_row_t row;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == STEP_REG)
        write_reg(row.reg_idx, row.beat.mask_value[IMG_W-1:0]);
      else if (row.beat.opcode == OP_LOAD)
        send_beat(row.beat, 1'b0, NO_PIXEL);
      else
        send_pixel(row.beat, row.typed, row.want);
    end
  endtask

  task automatic run_random();
    int phase, stop_at, i;
    int scale_raw, width_raw, height_raw, wide, chans;
    int s, w, h, mw, mh, span, pixel_total;
    bit big;
    bit pressure_done;
    mmu_in_t beat;
    phase = 0;
    pressure_done = 1'b0;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      big = ($urandom_range(9) == 0);
      if (big) begin
        // Huge frames are only entered; the next phase rewrites the geometry mid-frame.
        case ($urandom_range(3))
          0: scale_raw = 16;
          1: scale_raw = 31;
          2: scale_raw = 1;
          default: scale_raw = $urandom_range(15, 2);
        endcase
        case ($urandom_range(2))
          0: width_raw = 4096;
          1: width_raw = 8191;
          default: width_raw = 4095;
        endcase
        height_raw = $urandom_range(1) ? 8191 : $urandom_range(3, 1);
        pixel_total = $urandom_range(60, 20);
      end else begin
        case ($urandom_range(9))
          0: scale_raw = 0;
          1: scale_raw = 16;
          2: scale_raw = $urandom_range(8, 5);
          default: scale_raw = $urandom_range(4, 1);
        endcase
        s = scale_of(SCL_W'(scale_raw));
        width_raw = s * $urandom_range((s >= 8) ? 1 : 3, 1);
        if (s > 1 && $urandom_range(7) == 0) width_raw += $urandom_range(s - 1, 1);
        if ($urandom_range(15) == 0) width_raw = 0;
        height_raw = (s >= 8) ? $urandom_range(s, 1) : s * $urandom_range(3, 1);
        if (s > 1 && $urandom_range(7) == 0) height_raw += $urandom_range(s - 1, 1);
        if ($urandom_range(15) == 0) height_raw = 0;
        w = clamp_dim(IMG_W'(width_raw));
        h = clamp_dim(IMG_W'(height_raw));
        pixel_total = ($urandom_range(3) == 0) ? $urandom_range(2 * w * h, 1)
                                               : w * h * $urandom_range(2, 1);
      end
      wide = $urandom_range(1);
      chans = ($urandom_range(4) == 0) ? $urandom_range(7) : ($urandom_range(1) ? 3 : 4);
      write_reg(CFG_IMAGE_WIDTH, with_junk(width_raw, IMG_W));
      write_reg(CFG_IMAGE_HEIGHT, with_junk(height_raw, IMG_W));
      write_reg(CFG_SCALE, with_junk(scale_raw, SCL_W));
      write_reg(CFG_WIDE_SAMPLES, with_junk(wide, 1));
      write_reg(CFG_CHANNEL_COUNT, with_junk(chans, CNT_W));

      // Load the mask region of a fresh frame in raster order.
      s = scale_of(cfg_scale);
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      mw = (w + s - 1) / s;
      mh = (h + s - 1) / s;
      span = (mh - 1) * (w / s) + mw;
      if (span > PRELOAD_MAX) span = PRELOAD_MAX;
      for (i = 0; i < span; i++) send_load(SAMP_W'(i), pick_sample());

      // The first phase always carries the long hold-off, with enough pixels to fill up.
      if (!pressure_done && phase % 4 == 0) begin
        if (pixel_total < 24) pixel_total = 24;
        hold_requests++;
        pressure_done = 1'b1;
      end
      for (i = 0; i < pixel_total; i++) begin
        if ($urandom_range(11) == 0) send_load(SAMP_W'($urandom), pick_sample());
        beat = '{OP_PIXEL, SAMP_W'($urandom), SAMP_W'($urandom), pick_sample(),
                 pick_sample(), pick_sample(), pick_sample()};
        send_pixel(beat, 1'b0, NO_PIXEL);
      end
      phase++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    hold_taken = 0;
    hold_left = 0;
    cycle_count = 0;
    mismatches = 0;
    beats_sent = 0;
    cfg_width = IMG_W'(1);
    cfg_height = IMG_W'(1);
    cfg_scale = SCL_W'(1);
    cfg_wide = 1'b0;
    cfg_chans = CNT_W'(4);
    pix_col = '0; pix_row = '0; col_phase = '0; row_phase = '0;
    mask_col = '0; mask_base = '0;
    foreach (mask_written[i]) mask_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    drain();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
